// ===== rtl/mecanum_wheel_speed_pid_macros.svh =====
// Assertion macros shared by the mecanum wheel speed controller RTL.
`ifndef MECANUM_WHEEL_SPEED_PID_MACROS_SVH
`define MECANUM_WHEEL_SPEED_PID_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MWSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MWSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mwsp_pkg.sv =====
// Constants, types and codes of the mecanum wheel speed controller.
package mwsp_pkg;

  localparam int unsigned WINDOW_LEN = 10;
  localparam int unsigned WHEELS     = 4;
  localparam int unsigned WHEEL_W    = 2;
  localparam int unsigned VEL_W      = 14;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned GAINS_W    = 48;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned TGT_W      = 16;
  localparam int unsigned ERR_W      = 18;
  localparam int unsigned D1_W       = ERR_W + 1;
  localparam int unsigned D2_W       = ERR_W + 2;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned PROD_W     = GAIN_W + 1 + D2_W;
  localparam int unsigned MAC_W      = PROD_W + 2;
  localparam int unsigned SUM_W      = CNT_W + $clog2(WINDOW_LEN + 1);
  localparam int unsigned RING_W     = $clog2(WINDOW_LEN);

  // The window average is a multiply by a rounded-up reciprocal and a shift.
  localparam int unsigned DIV_SHIFT  = 2 * SUM_W - 16;
  localparam int unsigned RECIP_W    = DIV_SHIFT - $clog2(WINDOW_LEN) + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd900;

  localparam logic [WHEEL_W-1:0] WHEEL_ONE   = 2'd0;
  localparam logic [WHEEL_W-1:0] WHEEL_TWO   = 2'd1;
  localparam logic [WHEEL_W-1:0] WHEEL_THREE = 2'd2;
  localparam logic [WHEEL_W-1:0] WHEEL_FOUR  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP  = 2'd0,
    CFG_INTEG = 2'd1,
    CFG_DERIV = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                        valid;
    logic [WHEEL_W-1:0]          wheel;
    logic                        first;
    logic signed [TGT_W-1:0]     tgt;
    logic signed [CNT_W-1:0]     cnt;
    logic [GAIN_W-1:0]           kp;
    logic [GAIN_W-1:0]           ki;
    logic [GAIN_W-1:0]           kd;
    logic [WHEELS*CNT_W-1:0]     counts;
  } wheel_issue_t;

  typedef struct packed {
    logic                        valid;
    logic [WHEEL_W-1:0]          wheel;
    logic signed [DRIVE_W-1:0]   drive;
  } wheel_drive_t;

endpackage

// ===== rtl/mwsp_cmd_if.sv =====
// Command channel: velocity commands and encoder counts of one period.
interface mwsp_cmd_if;
  import mwsp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_rot;
  logic signed [CNT_W-1:0] enc_one;
  logic signed [CNT_W-1:0] enc_two;
  logic signed [CNT_W-1:0] enc_three;
  logic signed [CNT_W-1:0] enc_four;

  modport source (
    output valid, vel_x, vel_y, vel_rot, enc_one, enc_two, enc_three, enc_four,
    input  ready
  );

  modport sink (
    input  valid, vel_x, vel_y, vel_rot, enc_one, enc_two, enc_three, enc_four,
    output ready
  );

endinterface

// ===== rtl/mwsp_drive_if.sv =====
// Result channel: the four clamped wheel drive values.
interface mwsp_drive_if;
  import mwsp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_one;
  logic signed [DRIVE_W-1:0] drive_two;
  logic signed [DRIVE_W-1:0] drive_three;
  logic signed [DRIVE_W-1:0] drive_four;

  modport source (
    output valid, drive_one, drive_two, drive_three, drive_four,
    input  ready
  );

  modport sink (
    input  valid, drive_one, drive_two, drive_three, drive_four,
    output ready
  );

endinterface

// ===== rtl/mwsp_core.sv =====
// Per-wheel filter and PID pipeline around the sample ring and wheel state memories.
`include "mecanum_wheel_speed_pid_macros.svh"

module mwsp_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  mwsp_pkg::wheel_issue_t          issue,
  input  logic [mwsp_pkg::LIMIT_W-1:0]    drive_limit,
  output mwsp_pkg::wheel_drive_t          fin
);
  import mwsp_pkg::*;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e2;
    logic signed [ACC_W-1:0] acc;
  } wheel_state_t;

  typedef struct packed {
    logic                    valid;
    logic [WHEEL_W-1:0]      wheel;
    logic signed [TGT_W-1:0] tgt;
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic [GAIN_W-1:0]       kd;
  } ctl_t;

  // Sample ring, one word of four counts per entry.
  logic [WHEELS*CNT_W-1:0] ring_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]   ring_fill;
  logic [RING_W-1:0]       ring_pos;
  logic [WHEELS*CNT_W-1:0] ring_rd;
  logic                    ring_rd_ok;

  // Wheel state, one entry per wheel.
  wheel_state_t            state_mem [WHEELS];
  logic [WHEELS-1:0]       state_fill;
  wheel_state_t            state_rd;
  logic                    state_rd_ok;

  // Copy of the last entry written, for a read that hit the same edge.
  logic                    hold_valid;
  logic [WHEEL_W-1:0]      hold_wheel;
  wheel_state_t            hold_data;

  ctl_t c1, c2, c3, c4, c5, c6;

  logic signed [CNT_W-1:0]       cnt1;
  wheel_state_t                  st2, st3, st4, st5;
  logic                          neg2, neg3;
  logic [SUM_W-1:0]              mag2;
  logic [CNT_W:0]                quot3;
  logic signed [ERR_W-1:0]       err4;
  logic signed [D1_W-1:0]        d1_4;
  logic signed [D2_W-1:0]        d2_4;
  logic signed [PROD_W-1:0]      p5, i5, d5;
  logic signed [ACC_W-1:0]       acc6;

  wheel_state_t                  cur;
  wheel_state_t                  wb;
  logic signed [CNT_W-1:0]       old_cnt;
  logic signed [SUM_W-1:0]       sum_new;
  logic                          neg;
  logic [SUM_W-1:0]              mag;
  logic [SUM_W+RECIP_W-1:0]      qprod;
  logic signed [ERR_W-1:0]       qs, filt, err;
  logic signed [D1_W-1:0]        d1;
  logic signed [D2_W-1:0]        d2;
  logic signed [PROD_W-1:0]      pterm, iterm, dterm;
  logic signed [MAC_W-1:0]       mac, lim;
  logic signed [ACC_W-1:0]       acc_new;
  logic signed [ACC_W-1:0]       rnd;

  wire ring_access = advance && issue.valid && issue.first;

  always_ff @(posedge clk) begin
    if (ring_access) begin
      ring_rd <= ring_mem[ring_pos];
      ring_mem[ring_pos] <= issue.counts;
    end
    if (advance && issue.valid) begin
      state_rd <= state_mem[issue.wheel];
    end
    if (advance && c5.valid) begin
      state_mem[c5.wheel] <= wb;
      hold_data <= wb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_fill   <= '0;
      ring_pos    <= '0;
      ring_rd_ok  <= 1'b0;
      state_fill  <= '0;
      state_rd_ok <= 1'b0;
      hold_valid  <= 1'b0;
      hold_wheel  <= '0;
    end else begin
      if (ring_access) begin
        ring_rd_ok <= ring_fill[ring_pos];
        ring_fill[ring_pos] <= 1'b1;
        ring_pos <= (ring_pos == RING_W'(WINDOW_LEN - 1)) ? '0 : ring_pos + 1'b1;
      end
      if (advance && issue.valid) begin
        state_rd_ok <= state_fill[issue.wheel];
      end
      if (advance && c5.valid) begin
        state_fill[c5.wheel] <= 1'b1;
        hold_valid <= 1'b1;
        hold_wheel <= c5.wheel;
      end
    end
  end

  // Stage 1: window sum update with forwarding from the write-back stage.
  always_comb begin
    if (c5.valid && c5.wheel == c1.wheel) begin
      cur = wb;
    end else if (hold_valid && hold_wheel == c1.wheel) begin
      cur = hold_data;
    end else if (state_rd_ok) begin
      cur = state_rd;
    end else begin
      cur = '0;
    end
    old_cnt = ring_rd_ok ? ring_rd[c1.wheel*CNT_W +: CNT_W] : '0;
    sum_new = cur.sum + SUM_W'(cnt1) - SUM_W'(old_cnt);
    neg     = sum_new[SUM_W-1];
    mag     = neg ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  end

  // Stage 2: magnitude of the window average.
  assign qprod = (SUM_W+RECIP_W)'(mag2) * (SUM_W+RECIP_W)'(RECIP);

  // Stage 3: error and its differences.
  always_comb begin
    qs   = ERR_W'(quot3);
    filt = neg3 ? -qs : qs;
    err  = ERR_W'(c3.tgt) - filt;
    d1   = D1_W'(err) - D1_W'(st3.e1);
    d2   = D2_W'(err) - (D2_W'(st3.e1) <<< 1) + D2_W'(st3.e2);
  end

  // Stage 4: gain products.
  always_comb begin
    pterm = $signed({1'b0, c4.kp}) * d1_4;
    iterm = $signed({1'b0, c4.ki}) * err4;
    dterm = $signed({1'b0, c4.kd}) * d2_4;
  end

  // Stage 5: accumulate, clamp and write back.
  always_comb begin
    mac = MAC_W'(st5.acc) + MAC_W'(p5) + MAC_W'(i5) + MAC_W'(d5);
    lim = $signed(MAC_W'({drive_limit, FRAC_W'(0)}));
    if (mac > lim) begin
      acc_new = ACC_W'(lim);
    end else if (mac < -lim) begin
      acc_new = ACC_W'(-lim);
    end else begin
      acc_new = ACC_W'(mac);
    end
    wb     = st5;
    wb.acc = acc_new;
  end

  // Stage 6: integer part, truncated toward zero.
  always_comb begin
    rnd       = acc6 + $signed(ACC_W'({FRAC_W{acc6[ACC_W-1]}}));
    fin.valid = c6.valid;
    fin.wheel = c6.wheel;
    fin.drive = DRIVE_W'(rnd >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (advance) begin
      c1 <= '{valid: issue.valid, wheel: issue.wheel, tgt: issue.tgt,
              kp: issue.kp, ki: issue.ki, kd: issue.kd};
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      c6 <= c5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cnt1     <= issue.cnt;
      st2      <= '{sum: sum_new, e1: cur.e1, e2: cur.e2, acc: cur.acc};
      neg2     <= neg;
      mag2     <= mag;
      st3      <= st2;
      neg3     <= neg2;
      quot3    <= qprod[DIV_SHIFT +: CNT_W+1];
      st4      <= '{sum: st3.sum, e1: err, e2: st3.e1, acc: st3.acc};
      err4     <= err;
      d1_4     <= d1;
      d2_4     <= d2;
      st5      <= st4;
      p5       <= pterm;
      i5       <= iterm;
      d5       <= dterm;
      acc6     <= acc_new;
    end
  end

  `MWSP_ASSERT_IMPL(a_wheel_order, clk, rst, c1.valid && c2.valid, c1.wheel == WHEEL_W'(c2.wheel + 1'b1), "wheels left issue order")
  `MWSP_ASSERT_IMPL(a_ring_pos_range, clk, rst, 1'b1, ring_pos <= RING_W'(WINDOW_LEN - 1), "ring position out of range")
  `MWSP_ASSERT_IMPL(a_drive_in_limit, clk, rst, fin.valid, (fin.drive <= $signed({1'b0, drive_limit})) && (fin.drive >= -$signed({1'b0, drive_limit})), "drive exceeds limit")

endmodule

// ===== rtl/mecanum_wheel_speed_pid.sv =====
// Top level of the mecanum wheel speed controller: configuration, wheel sequencer, result word.
//
//   channel   direction  word
//   cmd       in         vel_x, vel_y, vel_rot, enc_one .. enc_four
//   result    out        drive_one .. drive_four
//   cfg       in         cfg_write_en, cfg_index, cfg_data (write only)
//
// The wheels of a command word pass one per cycle, unless the pipeline is stopped, through a shared
// pipeline whose wheel state memory has one read and one write port.
// A result word is loaded into the result register when its fourth wheel leaves the core.
// Reset clears no memory: ring and wheel state entries read as zero until first written.
// The pipeline stops only when a finished word cannot enter the occupied result register.
`include "mecanum_wheel_speed_pid_macros.svh"

module mecanum_wheel_speed_pid (
  input  logic                              clk,
  input  logic                              rst,
  mwsp_cmd_if.sink                          cmd,
  mwsp_drive_if.source                      result,
  input  logic                              cfg_write_en,
  input  logic [mwsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mwsp_pkg::*;

  logic [GAINS_W-1:0]        prop_gains;
  logic [GAINS_W-1:0]        integ_gains;
  logic [GAINS_W-1:0]        deriv_gains;
  logic [LIMIT_W-1:0]        drive_limit;

  logic                      busy;
  logic [WHEEL_W-1:0]        slot;
  logic signed [VEL_W-1:0]   vx, vy, vr;
  logic [WHEELS*CNT_W-1:0]   counts;

  logic signed [TGT_W-1:0]   ex, ey, er;
  logic signed [DRIVE_W-1:0] held_one, held_two, held_three;

  wheel_issue_t              issue;
  wheel_drive_t              fin;
  logic                      advance;
  logic                      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gains  <= '0;
      integ_gains <= '0;
      deriv_gains <= '0;
      drive_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP:  prop_gains  <= cfg_data[GAINS_W-1:0];
        CFG_INTEG: integ_gains <= cfg_data[GAINS_W-1:0];
        CFG_DERIV: deriv_gains <= cfg_data[GAINS_W-1:0];
        CFG_LIMIT: drive_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = !(fin.valid && fin.wheel == WHEEL_FOUR && result.valid && !result.ready);
  assign cmd.ready = advance && (!busy || slot == WHEEL_FOUR);
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      slot <= WHEEL_ONE;
    end else if (advance && busy) begin
      if (slot == WHEEL_FOUR) begin
        busy <= 1'b0;
      end
      slot <= slot + 1'b1;
    end
  end

  always_comb begin
    ex = TGT_W'(vx);
    ey = TGT_W'(vy);
    er = TGT_W'(vr);
    issue.valid  = busy;
    issue.wheel  = slot;
    issue.first  = (slot == WHEEL_ONE);
    case (slot)
      WHEEL_ONE:   issue.tgt = ey - ex - er;
      WHEEL_TWO:   issue.tgt = ey + ex + er;
      WHEEL_THREE: issue.tgt = ey - ex + er;
      WHEEL_FOUR:  issue.tgt = ey + ex - er;
      default:     issue.tgt = '0;
    endcase
    issue.cnt    = counts[slot*CNT_W +: CNT_W];
    issue.kp     = prop_gains[slot*GAIN_W +: GAIN_W];
    issue.ki     = integ_gains[slot*GAIN_W +: GAIN_W];
    issue.kd     = deriv_gains[slot*GAIN_W +: GAIN_W];
    issue.counts = counts;
  end

  mwsp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .issue       (issue),
    .drive_limit (drive_limit),
    .fin         (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      result.valid <= (advance && fin.valid && fin.wheel == WHEEL_FOUR) ||
                      (result.valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx     <= cmd.vel_x;
      vy     <= cmd.vel_y;
      vr     <= cmd.vel_rot;
      counts <= {cmd.enc_four, cmd.enc_three, cmd.enc_two, cmd.enc_one};
    end
    if (advance && fin.valid) begin
      case (fin.wheel)
        WHEEL_ONE:   held_one   <= fin.drive;
        WHEEL_TWO:   held_two   <= fin.drive;
        WHEEL_THREE: held_three <= fin.drive;
        WHEEL_FOUR: begin
          result.drive_one   <= held_one;
          result.drive_two   <= held_two;
          result.drive_three <= held_three;
          result.drive_four  <= fin.drive;
        end
        default: ;
      endcase
    end
  end

  `MWSP_ASSERT_NEXT(a_accept_starts_item, clk, rst, accept, busy && slot == WHEEL_ONE, "accepted word did not start at wheel one")
  `MWSP_ASSERT_IMPL(a_no_accept_mid_item, clk, rst, busy && slot != WHEEL_FOUR, !cmd.ready, "ready raised in the middle of a word")
  `MWSP_ASSERT_NEXT(a_result_loaded, clk, rst, advance && fin.valid && fin.wheel == WHEEL_FOUR, result.valid, "finished word not presented")

endmodule
